// ===== hw/rtl/midpoint_ellipse_rasterizer_assert.svh =====
// Assertion macros used by the rasterizer controller.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising edge, disabled while reset is high.
`define MER_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, including during reset.
`define MER_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MER_ASSERT(lbl, clk, rst, prop, msg)
`define MER_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/mer_pkg.sv =====
package mer_pkg;

  // Field and datapath widths.
  localparam int CoordW = 7;
  localparam int RadW   = 5;
  localparam int SymW   = 8;
  localparam int PixW   = 8;
  localparam int StepXW = 6;
  localparam int StepYW = 7;
  localparam int SqW    = 10;
  localparam int GradW  = 18;
  localparam int DecW   = 27;
  localparam int MulAW  = 10;
  localparam int MulBW  = 14;
  localparam int ProdW  = MulAW + MulBW;
  localparam int CountW = 6;

  // Commands from the controller to the datapath.
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_MRX2,
    CMD_MRY2,
    CMD_MRXRY,
    CMD_INIT1,
    CMD_STEP1,
    CMD_MSQX,
    CMD_MA,
    CMD_MSQY,
    CMD_MB,
    CMD_MRR,
    CMD_INIT2,
    CMD_STEP2
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic r1_go;
    logic r2_go;
    logic last1;
    logic last2;
  } status_t;

endpackage

// ===== hw/rtl/midpoint_ellipse_rasterizer.sv =====
// Midpoint ellipse rasterizer. Each accepted item (centre, two radii up to
// MAX_RADIUS, symbol) produces one result per step of the two-region midpoint
// ellipse walk: the four symmetric points of the current offset and the symbol,
// with last_step set on the final result of the ellipse. Radii above
// MAX_RADIUS are clamped, and coordinates wrap to 8 bits. One item is worked at
// a time: the shared 10x14 multiplier forms the region one decision values
// in the MRX2, MRY2, MRXRY and INIT1 states and the region two values in the
// MSQX, MA, MSQY, MB, MRR and INIT2 states between the regions, and the step
// loop gives one result per cycle while the output is not stalled. A 30 by 30
// ellipse gives 43 results.
// A new item is taken in the cycle after the last result is produced, while
// that result may still wait in the output register.
module midpoint_ellipse_rasterizer #(
  parameter int MAX_RADIUS = 30
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [mer_pkg::CoordW-1:0]    center_x,
  input  logic signed [mer_pkg::CoordW-1:0]    center_y,
  input  logic        [mer_pkg::RadW-1:0]      radius_x,
  input  logic        [mer_pkg::RadW-1:0]      radius_y,
  input  logic        [mer_pkg::SymW-1:0]      symbol,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [mer_pkg::PixW-1:0]      px_right,
  output logic signed [mer_pkg::PixW-1:0]      px_left,
  output logic signed [mer_pkg::PixW-1:0]      py_up,
  output logic signed [mer_pkg::PixW-1:0]      py_down,
  output logic signed [mer_pkg::PixW-1:0]      q1_x,
  output logic signed [mer_pkg::PixW-1:0]      q1_y,
  output logic signed [mer_pkg::PixW-1:0]      q3_x,
  output logic signed [mer_pkg::PixW-1:0]      q3_y,
  output logic        [mer_pkg::SymW-1:0]      glyph,
  output logic                                 last_step
);
  import mer_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  mer_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // Arithmetic and output register.
  mer_dpath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dpath (
    .clk       (clk),
    .cmd       (cmd),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_x  (radius_x),
    .radius_y  (radius_y),
    .symbol    (symbol),
    .px_right  (px_right),
    .px_left   (px_left),
    .py_up     (py_up),
    .py_down   (py_down),
    .glyph     (glyph),
    .last_step (last_step),
    .status    (status)
  );

  // Quadrant points repeat the symmetric coordinates.
  assign q1_x = px_right;
  assign q1_y = py_up;
  assign q3_x = px_left;
  assign q3_y = py_down;

endmodule

// ===== hw/rtl/mer_ctrl.sv =====
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output mer_pkg::cmd_t     cmd,
  input  mer_pkg::status_t  status
);
  import mer_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MRX2  = 13'b0000000000010,
    S_MRY2  = 13'b0000000000100,
    S_MRXRY = 13'b0000000001000,
    S_INIT1 = 13'b0000000010000,
    S_STEP1 = 13'b0000000100000,
    S_MSQX  = 13'b0000001000000,
    S_MA    = 13'b0000010000000,
    S_MSQY  = 13'b0000100000000,
    S_MB    = 13'b0001000000000,
    S_MRR   = 13'b0010000000000,
    S_INIT2 = 13'b0100000000000,
    S_STEP2 = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   out_free;

  // The output register can take a new item when empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = rst || (state != S_IDLE);

  // Sequencer: setup products, region one steps, region two setup and steps.
  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = S_MRX2;
        end
      end
      S_MRX2: begin
        cmd        = CMD_MRX2;
        state_next = S_MRY2;
      end
      S_MRY2: begin
        cmd        = CMD_MRY2;
        state_next = S_MRXRY;
      end
      S_MRXRY: begin
        cmd        = CMD_MRXRY;
        state_next = S_INIT1;
      end
      S_INIT1: begin
        cmd        = CMD_INIT1;
        state_next = S_STEP1;
      end
      S_STEP1: begin
        if (!status.r1_go) begin
          state_next = S_MSQX;
        end else if (out_free) begin
          cmd = CMD_STEP1;
          if (status.last1) begin
            state_next = S_IDLE;
          end
        end
      end
      S_MSQX: begin
        cmd        = CMD_MSQX;
        state_next = S_MA;
      end
      S_MA: begin
        cmd        = CMD_MA;
        state_next = S_MSQY;
      end
      S_MSQY: begin
        cmd        = CMD_MSQY;
        state_next = S_MB;
      end
      S_MB: begin
        cmd        = CMD_MB;
        state_next = S_MRR;
      end
      S_MRR: begin
        cmd        = CMD_MRR;
        state_next = S_INIT2;
      end
      S_INIT2: begin
        cmd        = CMD_INIT2;
        state_next = S_STEP2;
      end
      S_STEP2: begin
        if (!status.r2_go) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          cmd = CMD_STEP2;
          if (status.last2) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Output valid flag: set by a loop step, cleared when the item is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == CMD_STEP1 || cmd == CMD_STEP2) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `MER_ASSERT(a_step_has_room, clk, rst, (cmd == CMD_STEP1 || cmd == CMD_STEP2) |-> (!out_valid || !out_stall), "loop step issued while the output register is held")
  `MER_ASSERT(a_region_one_cond, clk, rst, (cmd == CMD_STEP1) |-> status.r1_go, "region one step issued with dx not below dy")
  `MER_ASSERT(a_load_starts_setup, clk, rst, (cmd == CMD_LOAD) |=> (state == S_MRX2 && in_stall), "accepted item did not start the setup sequence")
  `MER_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> (state == S_IDLE && !out_valid), "block not idle after reset")

endmodule

// ===== hw/rtl/mer_dpath.sv =====
module mer_dpath #(
  parameter int MAX_RADIUS = 30
) (
  input  logic                                 clk,
  input  mer_pkg::cmd_t                        cmd,
  input  logic signed [mer_pkg::CoordW-1:0]    center_x,
  input  logic signed [mer_pkg::CoordW-1:0]    center_y,
  input  logic        [mer_pkg::RadW-1:0]      radius_x,
  input  logic        [mer_pkg::RadW-1:0]      radius_y,
  input  logic        [mer_pkg::SymW-1:0]      symbol,
  output logic signed [mer_pkg::PixW-1:0]      px_right,
  output logic signed [mer_pkg::PixW-1:0]      px_left,
  output logic signed [mer_pkg::PixW-1:0]      py_up,
  output logic signed [mer_pkg::PixW-1:0]      py_down,
  output logic        [mer_pkg::SymW-1:0]      glyph,
  output logic                                 last_step,
  output mer_pkg::status_t                     status
);
  import mer_pkg::*;

  localparam logic [RadW-1:0] RadMax = RadW'(MAX_RADIUS);

  // Request and working registers.
  logic        [CoordW-1:0] cx, cy;
  logic        [RadW-1:0]   rx, ry;
  logic        [SymW-1:0]   sym;
  logic        [SqW-1:0]    rx2, ry2;
  logic        [StepXW-1:0] x;
  logic signed [StepYW-1:0] y;
  logic signed [GradW-1:0]  dx, dy;
  logic signed [DecW-1:0]   d, acc;
  logic        [ProdW-1:0]  prod;
  logic        [CountW-1:0] cnt;

  // Combinational helpers.
  logic        [RadW-1:0]   rx_clamp, ry_clamp;
  logic        [MulAW-1:0]  mul_a;
  logic        [MulBW-1:0]  mul_b;
  logic        [ProdW-1:0]  mul_p;
  logic        [StepYW:0]   odd_x;
  logic signed [StepYW:0]   ym1;
  logic        [StepYW:0]   ym1_abs;
  logic signed [GradW-1:0]  ry2_x2, rx2_x2, dx_inc, dy_dec;
  logic signed [DecW-1:0]   dx_inc_e, dy_dec_e, ry2_e, rx2_e, prod_e;
  logic signed [StepYW-1:0] y_dec;
  logic        [StepXW-1:0] x_inc;

  // Next values for a region one step and a region two step.
  logic signed [StepYW-1:0] y_n1;
  logic signed [GradW-1:0]  dy_n1;
  logic signed [DecW-1:0]   d_n1, d_n2;
  logic        [StepXW-1:0] x_n2;
  logic signed [GradW-1:0]  dx_n2;

  // Result fields of the current offset.
  logic        [PixW-1:0]   cx_e, cy_e, x_e, y_e;

  assign rx_clamp = (radius_x > RadMax) ? RadMax : radius_x;
  assign ry_clamp = (radius_y > RadMax) ? RadMax : radius_y;

  // Operand selection for the shared multiplier.
  assign odd_x   = {1'b0, x, 1'b1};
  assign ym1     = {y[StepYW-1], y} - (StepYW+1)'(1);
  assign ym1_abs = ym1[StepYW] ? (StepYW+1)'(-ym1) : ym1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      CMD_MRX2: begin
        mul_a = MulAW'(rx);
        mul_b = MulBW'(rx);
      end
      CMD_MRY2: begin
        mul_a = MulAW'(ry);
        mul_b = MulBW'(ry);
      end
      CMD_MRXRY: begin
        mul_a = rx2;
        mul_b = MulBW'(ry);
      end
      CMD_MSQX: begin
        mul_a = MulAW'(odd_x);
        mul_b = MulBW'(odd_x);
      end
      CMD_MA: begin
        mul_a = ry2;
        mul_b = prod[MulBW-1:0];
      end
      CMD_MSQY: begin
        mul_a = MulAW'(ym1_abs);
        mul_b = MulBW'(ym1_abs);
      end
      CMD_MB: begin
        mul_a = rx2;
        mul_b = prod[MulBW-1:0];
      end
      CMD_MRR: begin
        mul_a = rx2;
        mul_b = MulBW'(ry2);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Sign and zero extensions into the gradient and decision widths.
  assign ry2_x2   = $signed({{(GradW-SqW-1){1'b0}}, ry2, 1'b0});
  assign rx2_x2   = $signed({{(GradW-SqW-1){1'b0}}, rx2, 1'b0});
  assign dx_inc   = dx + ry2_x2;
  assign dy_dec   = dy - rx2_x2;
  assign dx_inc_e = {{(DecW-GradW){dx_inc[GradW-1]}}, dx_inc};
  assign dy_dec_e = {{(DecW-GradW){dy_dec[GradW-1]}}, dy_dec};
  assign ry2_e    = $signed({{(DecW-SqW){1'b0}}, ry2});
  assign rx2_e    = $signed({{(DecW-SqW){1'b0}}, rx2});
  assign prod_e   = $signed({{(DecW-ProdW){1'b0}}, prod});
  assign y_dec    = y - StepYW'(1);
  assign x_inc    = x + StepXW'(1);

  // Region one step: x always advances, y drops when the decision is not negative.
  always_comb begin
    if (d[DecW-1]) begin
      y_n1  = y;
      dy_n1 = dy;
      d_n1  = d + ((dx_inc_e + ry2_e) <<< 2);
    end else begin
      y_n1  = y_dec;
      dy_n1 = dy_dec;
      d_n1  = d + ((dx_inc_e - dy_dec_e + ry2_e) <<< 2);
    end
  end

  // Region two step: y always drops, x advances when the decision is not positive.
  always_comb begin
    if (!d[DecW-1] && (d != '0)) begin
      x_n2  = x;
      dx_n2 = dx;
      d_n2  = d + ((rx2_e - dy_dec_e) <<< 2);
    end else begin
      x_n2  = x_inc;
      dx_n2 = dx_inc;
      d_n2  = d + ((dx_inc_e - dy_dec_e + rx2_e) <<< 2);
    end
  end

  // Loop conditions and the last-result flags seen ahead of each step.
  assign status.r1_go = (dx < dy);
  assign status.r2_go = !y[StepYW-1];
  assign status.last1 = (cnt == '1) || (!(dx_inc < dy_n1) && y_n1[StepYW-1]);
  assign status.last2 = (cnt == '1) || y_dec[StepYW-1];

  // Four symmetric points of the current offset, wrapped to the pixel width.
  assign cx_e = {{(PixW-CoordW){cx[CoordW-1]}}, cx};
  assign cy_e = {{(PixW-CoordW){cy[CoordW-1]}}, cy};
  assign x_e  = {{(PixW-StepXW){1'b0}}, x};
  assign y_e  = {{(PixW-StepYW){y[StepYW-1]}}, y};

  // Working registers, updated per command.
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_LOAD: begin
        cx  <= center_x;
        cy  <= center_y;
        rx  <= rx_clamp;
        ry  <= ry_clamp;
        sym <= symbol;
        x   <= '0;
        y   <= $signed({{(StepYW-RadW){1'b0}}, ry_clamp});
        cnt <= '0;
      end
      CMD_MRX2: begin
        prod <= mul_p;
      end
      CMD_MRY2: begin
        rx2  <= prod[SqW-1:0];
        prod <= mul_p;
      end
      CMD_MRXRY: begin
        ry2  <= prod[SqW-1:0];
        prod <= mul_p;
      end
      CMD_INIT1: begin
        d  <= (ry2_e <<< 2) - (prod_e <<< 2) + rx2_e;
        dx <= '0;
        dy <= $signed({prod[GradW-2:0], 1'b0});
      end
      CMD_STEP1: begin
        x   <= x_inc;
        y   <= y_n1;
        dx  <= dx_inc;
        dy  <= dy_n1;
        d   <= d_n1;
        cnt <= cnt + CountW'(1);
      end
      CMD_MSQX, CMD_MA, CMD_MB: begin
        prod <= mul_p;
      end
      CMD_MSQY: begin
        acc  <= prod_e;
        prod <= mul_p;
      end
      CMD_MRR: begin
        acc  <= acc + (prod_e <<< 2);
        prod <= mul_p;
      end
      CMD_INIT2: begin
        d <= acc - (prod_e <<< 2);
      end
      CMD_STEP2: begin
        x   <= x_n2;
        y   <= y_dec;
        dx  <= dx_n2;
        dy  <= dy_dec;
        d   <= d_n2;
        cnt <= cnt + CountW'(1);
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

  // Output register, loaded by each loop step.
  always_ff @(posedge clk) begin
    if (cmd == CMD_STEP1 || cmd == CMD_STEP2) begin
      px_right  <= $signed(cx_e + x_e);
      px_left   <= $signed(cx_e - x_e);
      py_up     <= $signed(cy_e + y_e);
      py_down   <= $signed(cy_e - y_e);
      glyph     <= sym;
      last_step <= (cmd == CMD_STEP1) ? status.last1 : status.last2;
    end
  end

endmodule
